// ===== rtl/lru_key_value_cache_unit_assert.svh =====
// assertion macros for the lru key-value cache unit
// expects clk and rst_n in the scope that uses them
`ifndef LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH

// property holds whenever the unit is out of reset
`define LKV_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lru cache assertion failed");

// consequence holds in the cycle after the antecedent
`define LKV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lru cache assertion failed");

`endif

// ===== rtl/lkv_pkg.sv =====
// shared types and constants for the lru key-value cache unit
// no dependencies
package lkv_pkg;

    localparam int SLOT_W = 8;  // enough for any slot index or age up to 256 entries

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    localparam logic [4:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic               action;
        logic signed [31:0] lookup_key;
        logic signed [31:0] store_value;
    } in_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
        logic               evicted;
        logic signed [31:0] evicted_key;
    } out_t;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] value;
    } kv_entry_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] found_slot;
        logic [SLOT_W-1:0] found_age;
        logic [31:0]       found_value;
        logic              free_found;
        logic [SLOT_W-1:0] free_slot;
        logic              victim_found;
        logic [SLOT_W-1:0] victim_slot;
        logic [SLOT_W-1:0] victim_age;
        logic [31:0]       victim_key;
    } scan_res_t;

endpackage

// ===== rtl/lru_key_value_cache_unit.sv =====
// top level of the lru key-value cache unit: sequencer, valid bits and ages
// uses lkv_pkg, lkv_mem, lkv_scan and lru_key_value_cache_unit_assert.svh
//
// Fully associative key-value cache with least-recently-used replacement.
// Each request is a get or a put and yields exactly one result. A request
// is accepted in the idle state; in the scan state the single key/age
// comparator walks the key/value ram one entry per cycle (the ram read port
// is registered, so the last compare lands after the last read is issued);
// the update state writes the ram, the valid bits and the recency ages and
// loads the result register, waiting while an earlier result is held by
// out_stall. in_stall is high in the scan and update states; the next request
// may be accepted while a finished result still waits on out_stall. The store
// starts empty after reset, with no clearing pass. The capacity register
// (reset 16) limits how many entries are filled before eviction and is read
// saturated at CAPACITY; with capacity zero a put on a new key is dropped.
`include "lru_key_value_cache_unit_assert.svh"

module lru_key_value_cache_unit #(
    parameter int CAPACITY = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    // configuration
    input  logic           cfg_write_en,
    input  logic [4:0]     cfg_write_data,
    // request channel
    input  logic           in_valid,
    output logic           in_stall,
    input  lkv_pkg::in_t   in_data,
    // result channel
    output logic           out_valid,
    input  logic           out_stall,
    output lkv_pkg::out_t  out_data
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = (CNT_W > 5) ? CNT_W : 5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 cmp_en_reg;
    logic [IDX_W-1:0]     cmp_idx_reg;
    lkv_pkg::in_t         req_reg;
    logic                 out_valid_reg;
    lkv_pkg::out_t        out_reg;

    logic [4:0]           capacity_in_use_reg;
    logic [CAPACITY-1:0]  valid_reg;
    logic [IDX_W-1:0]     age_reg [CAPACITY];
    logic [CNT_W-1:0]     used_count_reg;

    logic                 accept;
    logic                 do_update;
    logic                 issue;
    logic [IDX_W-1:0]     raddr;

    lkv_pkg::kv_entry_t   rdata;
    lkv_pkg::scan_res_t   scan_res;

    // update decisions
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    lkv_pkg::kv_entry_t   mem_wdata;
    logic                 touch_en;
    logic                 touch_old;
    logic [IDX_W-1:0]     touch_slot;
    logic [IDX_W-1:0]     touch_limit;
    logic                 fill;
    logic [CW-1:0]        cap_eff;
    lkv_pkg::out_t        result;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign do_update = (state_reg == ST_UPDATE) && (!out_valid_reg || !out_stall);
    assign issue     = (state_reg == ST_SCAN) && (cnt_reg < CNT_W'(CAPACITY));
    assign raddr     = cnt_reg[IDX_W-1:0];

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    lkv_mem #(
        .DEPTH (CAPACITY)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    lkv_scan #(
        .CAPACITY (CAPACITY)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .cmp_en     (cmp_en_reg),
        .cmp_idx    (cmp_idx_reg),
        .cmp_valid  (valid_reg[cmp_idx_reg]),
        .cmp_entry  (rdata),
        .cmp_age    (age_reg[cmp_idx_reg]),
        .lookup_key (req_reg.lookup_key),
        .res        (scan_res)
    );

    // effective capacity, saturated at the number of physical entries
    always_comb
    begin
        if (CW'(capacity_in_use_reg) > CW'(CAPACITY))
        begin
            cap_eff = CW'(CAPACITY);
        end
        else
        begin
            cap_eff = CW'(capacity_in_use_reg);
        end
    end

    // decide what the update cycle does
    always_comb
    begin
        mem_we      = 1'b0;
        mem_waddr   = scan_res.found_slot[IDX_W-1:0];
        mem_wdata   = '{key: req_reg.lookup_key, value: req_reg.store_value};
        touch_en    = 1'b0;
        touch_old   = 1'b1;
        touch_slot  = scan_res.found_slot[IDX_W-1:0];
        touch_limit = scan_res.found_age[IDX_W-1:0];
        fill        = 1'b0;
        result      = '0;

        if (scan_res.found)
        begin
            // hit: refresh recency, get returns the value, put overwrites it
            result.hit = 1'b1;
            touch_en   = do_update;
            if (req_reg.action == lkv_pkg::ACT_GET)
            begin
                result.read_value = scan_res.found_value;
            end
            else
            begin
                mem_we = do_update;
            end
        end
        else if (req_reg.action == lkv_pkg::ACT_PUT && cap_eff != '0)
        begin
            if (CW'(used_count_reg) < cap_eff && scan_res.free_found)
            begin
                // room left: take the first free slot, every other valid entry ages
                fill       = do_update;
                mem_we     = do_update;
                mem_waddr  = scan_res.free_slot[IDX_W-1:0];
                touch_en   = do_update;
                touch_old  = 1'b0;
                touch_slot = scan_res.free_slot[IDX_W-1:0];
            end
            else if (scan_res.victim_found)
            begin
                // full: replace the oldest entry in place
                result.evicted     = 1'b1;
                result.evicted_key = scan_res.victim_key;
                mem_we             = do_update;
                mem_waddr          = scan_res.victim_slot[IDX_W-1:0];
                touch_en           = do_update;
                touch_slot         = scan_res.victim_slot[IDX_W-1:0];
                touch_limit        = scan_res.victim_age[IDX_W-1:0];
            end
        end
    end

    // sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            cmp_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            cmp_en_reg <= issue;
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_SCAN;
                        cnt_reg   <= '0;
                    end
                end
                ST_SCAN:
                begin
                    if (issue)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    else
                    begin
                        // last compare lands at this edge
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    if (do_update)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg       <= result;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= in_data;
        end
        if (issue)
        begin
            cmp_idx_reg <= raddr;
        end
    end

    // capacity register, valid bits and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_in_use_reg <= lkv_pkg::CAP_RESET;
            valid_reg           <= '0;
            used_count_reg      <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                capacity_in_use_reg <= cfg_write_data;
            end
            if (fill)
            begin
                valid_reg[touch_slot] <= 1'b1;
                used_count_reg        <= used_count_reg + 1'b1;
            end
        end
    end

    // recency ages: touched slot becomes 0, younger valid entries (all valid entries on a fill) age by one
    always_ff @(posedge clk)
    begin
        if (touch_en)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (IDX_W'(i) == touch_slot)
                begin
                    age_reg[i] <= '0;
                end
                else if (valid_reg[i] && (!touch_old || age_reg[i] < touch_limit))
                begin
                    age_reg[i] <= age_reg[i] + 1'b1;
                end
            end
        end
    end

    // fill count tracks the valid bits
    `LKV_ASSERT(a_used_matches_valid, $countones(valid_reg) == CAPACITY'(used_count_reg))
    // an accepted request starts a scan from entry zero
    `LKV_ASSERT_NEXT(a_accept_starts_scan, accept, state_reg == ST_SCAN && cnt_reg == '0)
    // a completed update always presents a result
    `LKV_ASSERT_NEXT(a_update_gives_result, do_update, out_valid_reg && state_reg == ST_IDLE)
    // only a put ever changes the fill count
    `LKV_ASSERT_NEXT(a_fill_on_put, fill, req_reg.action == lkv_pkg::ACT_PUT && !out_reg.hit)

endmodule

// ===== rtl/lkv_mem.sv =====
// key/value storage ram, one write port and one registered read port
// uses lkv_pkg
module lkv_mem #(
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  lkv_pkg::kv_entry_t                    wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output lkv_pkg::kv_entry_t                    rdata
);

    lkv_pkg::kv_entry_t mem [DEPTH];
    lkv_pkg::kv_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lkv_scan.sv =====
// shared compare unit: checks one entry per cycle for key match, free slot
// and oldest entry; uses lkv_pkg
module lkv_scan #(
    parameter int CAPACITY = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    input  logic                                        cmp_en,
    input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] cmp_idx,
    input  logic                                        cmp_valid,
    input  lkv_pkg::kv_entry_t                          cmp_entry,
    input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] cmp_age,
    input  logic [31:0]                                 lookup_key,
    output lkv_pkg::scan_res_t                          res
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic             found_reg;
    logic [IDX_W-1:0] found_slot_reg;
    logic [IDX_W-1:0] found_age_reg;
    logic [31:0]      found_value_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_slot_reg;
    logic             victim_found_reg;
    logic [IDX_W-1:0] victim_slot_reg;
    logic [IDX_W-1:0] victim_age_reg;
    logic [31:0]      victim_key_reg;

    logic key_match;
    logic take_victim;

    assign key_match   = cmp_valid && (cmp_entry.key == lookup_key) && !found_reg;
    assign take_victim = cmp_valid && (!victim_found_reg || (cmp_age > victim_age_reg));

    // flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg        <= 1'b0;
            free_found_reg   <= 1'b0;
            victim_found_reg <= 1'b0;
        end
        else if (start)
        begin
            found_reg        <= 1'b0;
            free_found_reg   <= 1'b0;
            victim_found_reg <= 1'b0;
        end
        else if (cmp_en)
        begin
            if (key_match)
            begin
                found_reg <= 1'b1;
            end
            if (!cmp_valid)
            begin
                free_found_reg <= 1'b1;
            end
            if (take_victim)
            begin
                victim_found_reg <= 1'b1;
            end
        end
    end

    // captured payload
    always_ff @(posedge clk)
    begin
        if (cmp_en)
        begin
            if (key_match)
            begin
                found_slot_reg  <= cmp_idx;
                found_age_reg   <= cmp_age;
                found_value_reg <= cmp_entry.value;
            end
            if (!cmp_valid && !free_found_reg)
            begin
                free_slot_reg <= cmp_idx;
            end
            if (take_victim)
            begin
                victim_slot_reg <= cmp_idx;
                victim_age_reg  <= cmp_age;
                victim_key_reg  <= cmp_entry.key;
            end
        end
    end

    always_comb
    begin
        res.found        = found_reg;
        res.found_slot   = lkv_pkg::SLOT_W'(found_slot_reg);
        res.found_age    = lkv_pkg::SLOT_W'(found_age_reg);
        res.found_value  = found_value_reg;
        res.free_found   = free_found_reg;
        res.free_slot    = lkv_pkg::SLOT_W'(free_slot_reg);
        res.victim_found = victim_found_reg;
        res.victim_slot  = lkv_pkg::SLOT_W'(victim_slot_reg);
        res.victim_age   = lkv_pkg::SLOT_W'(victim_age_reg);
        res.victim_key   = victim_key_reg;
    end

endmodule
